// ----- sv/bilinear_image_scaler_defines.svh -----
// Assertion macros for the bilinear image scaler modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef BILINEAR_IMAGE_SCALER_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BIS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bis_pkg.sv -----
// Types and constants of the bilinear image scaler.
// Depends on nothing; imported by every module of the block but bis_ram.
package bis_pkg;

    localparam int COORD_W    = 12;
    localparam int SAMPLE_W   = 8;
    localparam int CHANNELS   = 4;
    localparam int PIXEL_W    = SAMPLE_W * CHANNELS;
    localparam int INV_W      = 24;
    localparam int SIZE_CFG_W = 9;
    localparam int CHAN_CFG_W = 3;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    typedef enum logic
    {
        OP_LOAD    = 1'b0,
        OP_REQUEST = 1'b1
    } bis_op_t;

    typedef enum logic [1:0]
    {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_CHANNEL_COUNT = 2'd2,
        REG_INVERSE_SCALE = 2'd3
    } bis_reg_t;

    typedef struct packed
    {
        logic                  req_type;
        logic [COORD_W-1:0]    coord_x;
        logic [COORD_W-1:0]    coord_y;
        logic [SAMPLE_W-1:0]   sample_0;
        logic [SAMPLE_W-1:0]   sample_1;
        logic [SAMPLE_W-1:0]   sample_2;
        logic [SAMPLE_W-1:0]   sample_3;
    } bis_req_t;

    typedef struct packed
    {
        logic [SAMPLE_W-1:0] value_0;
        logic [SAMPLE_W-1:0] value_1;
        logic [SAMPLE_W-1:0] value_2;
        logic [SAMPLE_W-1:0] value_3;
    } bis_result_t;

    typedef struct packed
    {
        logic [SIZE_CFG_W-1:0] image_width;
        logic [SIZE_CFG_W-1:0] image_height;
        logic [CHAN_CFG_W-1:0] active_channels;
        logic [INV_W-1:0]      inverse_scale;
    } bis_cfg_t;

endpackage

// ----- sv/bilinear_image_scaler.sv -----
// Bilinear image scaler top level: configuration registers, front end,
// work queue and back end. Depends on bis_pkg, bis_front, bis_queue, bis_back.
//
// Usage: a request on req is taken at a clock edge where start is high and
// busy is low. A load request (req_type 0) writes one pixel into the frame
// store; a pixel request (req_type 1) returns one blended pixel on result,
// marked by done for exactly one cycle; loads return nothing.
// One request per cycle is sustained while busy is low: the coordinate
// multiplier, the four frame store banks (one per row/column parity, so all
// four neighbours are read in the same cycle) and the blend multipliers are
// each one pipeline stage, with the work queue between the first two.
// The receiver cannot stall; results appear in request order.
// Registers must be written over APB with no request in flight (not enforced).
// Reset clears the control state and sets the registers to their defaults;
// the frame store is not cleared and must be loaded before it is read.
module bilinear_image_scaler
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  bis_req_t           req,
    output logic               done,
    output bis_result_t        result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int EW = 1 + 2 * XW + 2 * YW + 2 * FRAC_BITS + PIXEL_W;

    logic [SIZE_CFG_W-1:0] width_reg;
    logic [SIZE_CFG_W-1:0] height_reg;
    logic [CHAN_CFG_W-1:0] chan_reg;
    logic [INV_W-1:0]      inv_reg;
    bis_cfg_t              cfg;
    bis_reg_t              reg_sel;
    logic                  cfg_write;
    logic                  accept;
    logic                  push;
    logic [EW-1:0]         entry;
    logic                  pop;
    logic                  head_valid;
    logic [EW-1:0]         head_data;
    logic                  q_full;

    assign pready    = 1'b1;
    assign reg_sel   = bis_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            chan_reg   <= 3'd3;
            inv_reg    <= 24'd65536;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_IMAGE_WIDTH:   width_reg  <= pwdata[SIZE_CFG_W-1:0];
                REG_IMAGE_HEIGHT:  height_reg <= pwdata[SIZE_CFG_W-1:0];
                REG_CHANNEL_COUNT: chan_reg   <= pwdata[CHAN_CFG_W-1:0];
                REG_INVERSE_SCALE: inv_reg    <= pwdata[INV_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_IMAGE_WIDTH:   prdata = PDATA_W'(width_reg);
            REG_IMAGE_HEIGHT:  prdata = PDATA_W'(height_reg);
            REG_CHANNEL_COUNT: prdata = PDATA_W'(chan_reg);
            REG_INVERSE_SCALE: prdata = PDATA_W'(inv_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.image_width     = width_reg;
    assign cfg.image_height    = height_reg;
    assign cfg.active_channels = chan_reg;
    assign cfg.inverse_scale   = inv_reg;

    assign busy   = q_full;
    assign accept = start && !busy;

    bis_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS),
        .XW         (XW),
        .YW         (YW),
        .EW         (EW)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .cfg    (cfg),
        .push   (push),
        .entry  (entry)
    );

    bis_queue #(
        .WIDTH (EW),
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .full       (q_full)
    );

    bis_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS),
        .XW         (XW),
        .YW         (YW),
        .EW         (EW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .cfg        (cfg),
        .done       (done),
        .result     (result)
    );

endmodule

// ----- sv/bis_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/bis_front.sv -----
// Front end: registers a request, maps request coordinates to source positions
// and clamps them, then pushes a packed work entry. Depends on bis_pkg.
module bis_front
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 16,
    parameter int XW         = 8,
    parameter int YW         = 8,
    parameter int EW         = 97
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  bis_req_t      req,
    input  bis_cfg_t      cfg,
    output logic          push,
    output logic [EW-1:0] entry
);

    localparam int POS_W  = COORD_W + INV_W;
    localparam int BASE_W = POS_W - FRAC_BITS;
    localparam int CMPW   = BASE_W + 1;
    localparam int MAPW   = 2 * CMPW + FRAC_BITS;

    logic                 f1_valid_reg;
    bis_op_t              f1_op_reg;
    logic [COORD_W-1:0]   f1_x_reg;
    logic [COORD_W-1:0]   f1_y_reg;
    logic [PIXEL_W-1:0]   f1_data_reg;
    logic [POS_W-1:0]     f1_posx_reg;
    logic [POS_W-1:0]     f1_posy_reg;

    logic [CMPW-1:0]      eff_w;
    logic [CMPW-1:0]      eff_h;
    logic [MAPW-1:0]      map_x;
    logic [MAPW-1:0]      map_y;
    logic                 in_store;

    // Returns {base, next, frac}; a base past the edge pins to the edge.
    function automatic logic [MAPW-1:0] map_axis(input logic [POS_W-1:0] pos,
                                                 input logic [CMPW-1:0] size);
        logic [CMPW-1:0]      b;
        logic [CMPW-1:0]      n;
        logic [FRAC_BITS-1:0] f;
        f = pos[FRAC_BITS-1:0];
        if ({1'b0, pos[POS_W-1:FRAC_BITS]} >= size)
        begin
            b = size - CMPW'(1);
            f = '0;
        end
        else
        begin
            b = {1'b0, pos[POS_W-1:FRAC_BITS]};
        end
        n = (b + CMPW'(1) >= size) ? size - CMPW'(1) : b + CMPW'(1);
        return {b, n, f};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_op_reg   <= bis_op_t'(req.req_type);
            f1_x_reg    <= req.coord_x;
            f1_y_reg    <= req.coord_y;
            f1_data_reg <= {req.sample_3, req.sample_2, req.sample_1, req.sample_0};
            f1_posx_reg <= POS_W'(req.coord_x) * POS_W'(cfg.inverse_scale);
            f1_posy_reg <= POS_W'(req.coord_y) * POS_W'(cfg.inverse_scale);
        end
    end

    always_comb
    begin
        if (cfg.image_width == '0)
            eff_w = CMPW'(1);
        else if (CMPW'(cfg.image_width) > CMPW'(MAX_WIDTH))
            eff_w = CMPW'(MAX_WIDTH);
        else
            eff_w = CMPW'(cfg.image_width);

        if (cfg.image_height == '0)
            eff_h = CMPW'(1);
        else if (CMPW'(cfg.image_height) > CMPW'(MAX_HEIGHT))
            eff_h = CMPW'(MAX_HEIGHT);
        else
            eff_h = CMPW'(cfg.image_height);
    end

    assign map_x    = map_axis(f1_posx_reg, eff_w);
    assign map_y    = map_axis(f1_posy_reg, eff_h);
    assign in_store = ({1'b0, f1_x_reg} < (COORD_W+1)'(MAX_WIDTH))
                   && ({1'b0, f1_y_reg} < (COORD_W+1)'(MAX_HEIGHT));

    // Loads outside the store are dropped here and never reach the queue.
    always_comb
    begin
        unique case (f1_op_reg)
            OP_REQUEST:
            begin
                push  = f1_valid_reg;
                entry = {OP_REQUEST,
                         map_x[FRAC_BITS + CMPW +: XW],
                         map_x[FRAC_BITS +: XW],
                         map_y[FRAC_BITS + CMPW +: YW],
                         map_y[FRAC_BITS +: YW],
                         map_x[FRAC_BITS-1:0],
                         map_y[FRAC_BITS-1:0],
                         {PIXEL_W{1'b0}}};
            end
            OP_LOAD:
            begin
                push  = f1_valid_reg && in_store;
                entry = {OP_LOAD,
                         f1_x_reg[XW-1:0], f1_x_reg[XW-1:0],
                         f1_y_reg[YW-1:0], f1_y_reg[YW-1:0],
                         {FRAC_BITS{1'b0}}, {FRAC_BITS{1'b0}},
                         f1_data_reg};
            end
            default:
            begin
                push  = 1'b0;
                entry = '0;
            end
        endcase
    end

endmodule

// ----- sv/bis_queue.sv -----
// Short register queue between the front end and the back end.
// Depends on bis_pkg.
module bis_queue
    import bis_pkg::*;
#(
    parameter int WIDTH = 97,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data,
    output logic             full
);

    localparam int PTRW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg;
    logic [PTRW-1:0]  rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic             do_push;
    logic             do_pop;

    assign head_valid = count_reg != '0;
    assign head_data  = slot_reg[rd_ptr_reg];
    assign full       = count_reg == CNTW'(DEPTH);
    assign do_pop     = pop && head_valid;
    assign do_push    = push && (!full || do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTRW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTRW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNTW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- sv/bis_back.sv -----
// Back end: frame store in four row/column parity banks, neighbour fetch,
// weight products and per-channel blend. Depends on bis_pkg, bis_ram, macros.
`include "bilinear_image_scaler_defines.svh"
module bis_back
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 16,
    parameter int XW         = 8,
    parameter int YW         = 8,
    parameter int EW         = 97
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  logic [EW-1:0] head_data,
    output logic          pop,
    input  bis_cfg_t      cfg,
    output logic          done,
    output bis_result_t   result
);

    localparam int HW   = (MAX_WIDTH + 1) / 2;
    localparam int HH   = (MAX_HEIGHT + 1) / 2;
    localparam int BD   = HW * HH;
    localparam int BAW  = (BD > 1) ? $clog2(BD) : 1;
    localparam int WW   = 2 * FRAC_BITS + 1;
    localparam int SUMW = 2 * FRAC_BITS + 10;

    logic                 h_op;
    logic [XW-1:0]        h_x0;
    logic [XW-1:0]        h_x1;
    logic [YW-1:0]        h_y0;
    logic [YW-1:0]        h_y1;
    logic [FRAC_BITS-1:0] h_fx;
    logic [FRAC_BITS-1:0] h_fy;
    logic [PIXEL_W-1:0]   h_data;
    logic [FRAC_BITS:0]   ofx;
    logic [FRAC_BITS:0]   ofy;

    logic                 s1_valid_reg;
    bis_op_t              s1_op_reg;
    logic                 s1_x0p_reg;
    logic                 s1_x1p_reg;
    logic                 s1_y0p_reg;
    logic                 s1_y1p_reg;
    logic [WW-1:0]        w00_reg;
    logic [WW-1:0]        w10_reg;
    logic [WW-1:0]        w01_reg;
    logic [WW-1:0]        w11_reg;

    logic [PIXEL_W-1:0]   bank_rd [4];
    logic [PIXEL_W-1:0]   p00;
    logic [PIXEL_W-1:0]   p10;
    logic [PIXEL_W-1:0]   p01;
    logic [PIXEL_W-1:0]   p11;
    logic [CHAN_CFG_W-1:0] nch_eff;

    logic                 done_reg;
    logic [SAMPLE_W-1:0]  val_reg [CHANNELS];

    assign {h_op, h_x0, h_x1, h_y0, h_y1, h_fx, h_fy, h_data} = head_data;
    assign pop = head_valid;
    assign ofx = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, h_fx};
    assign ofy = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, h_fy};

    // Neighbouring columns and rows differ in parity, so each bank serves
    // exactly one of the four taps. A clamped pair reuses the same bank.
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic PX = 1'(b % 2);
        localparam logic PY = 1'(b / 2);
        logic [XW-1:0]  col;
        logic [YW-1:0]  row;
        logic [BAW-1:0] addr;
        logic           we;

        assign col  = (h_x0[0] == PX) ? h_x0 : h_x1;
        assign row  = (h_y0[0] == PY) ? h_y0 : h_y1;
        assign addr = BAW'(row >> 1) * BAW'(HW) + BAW'(col >> 1);
        assign we   = head_valid && (h_op == OP_LOAD) && (h_x0[0] == PX) && (h_y0[0] == PY);

        bis_ram #(
            .WIDTH (PIXEL_W),
            .DEPTH (BD),
            .AW    (BAW)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (addr),
            .wdata (h_data),
            .raddr (addr),
            .rdata (bank_rd[b])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= head_valid;
            done_reg     <= s1_valid_reg && (s1_op_reg == OP_REQUEST);
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_valid)
        begin
            s1_op_reg  <= bis_op_t'(h_op);
            s1_x0p_reg <= h_x0[0];
            s1_x1p_reg <= h_x1[0];
            s1_y0p_reg <= h_y0[0];
            s1_y1p_reg <= h_y1[0];
            w00_reg    <= WW'(ofx) * WW'(ofy);
            w10_reg    <= WW'(h_fx) * WW'(ofy);
            w01_reg    <= WW'(ofx) * WW'(h_fy);
            w11_reg    <= WW'(h_fx) * WW'(h_fy);
        end
    end

    assign p00 = bank_rd[{s1_y0p_reg, s1_x0p_reg}];
    assign p10 = bank_rd[{s1_y0p_reg, s1_x1p_reg}];
    assign p01 = bank_rd[{s1_y1p_reg, s1_x0p_reg}];
    assign p11 = bank_rd[{s1_y1p_reg, s1_x1p_reg}];

    always_comb
    begin
        if (cfg.active_channels == '0)
            nch_eff = CHAN_CFG_W'(1);
        else if (cfg.active_channels > CHAN_CFG_W'(CHANNELS))
            nch_eff = CHAN_CFG_W'(CHANNELS);
        else
            nch_eff = cfg.active_channels;
    end

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        logic [SUMW-1:0] sum;

        assign sum = SUMW'(w00_reg) * SUMW'(p00[c*SAMPLE_W +: SAMPLE_W])
                   + SUMW'(w10_reg) * SUMW'(p10[c*SAMPLE_W +: SAMPLE_W])
                   + SUMW'(w01_reg) * SUMW'(p01[c*SAMPLE_W +: SAMPLE_W])
                   + SUMW'(w11_reg) * SUMW'(p11[c*SAMPLE_W +: SAMPLE_W]);

        always_ff @(posedge clk)
        begin
            if (CHAN_CFG_W'(c) < nch_eff)
                val_reg[c] <= sum[2*FRAC_BITS +: SAMPLE_W];
            else
                val_reg[c] <= '0;
        end
    end

    assign done           = done_reg;
    assign result.value_0 = val_reg[0];
    assign result.value_1 = val_reg[1];
    assign result.value_2 = val_reg[2];
    assign result.value_3 = val_reg[3];

    `BIS_ASSERT_NEXT(a_req_gives_result, clk, rst_n, s1_valid_reg && (s1_op_reg == OP_REQUEST), done_reg, "request in fetch stage gave no result")
    `BIS_ASSERT_NEXT(a_load_is_silent, clk, rst_n, s1_valid_reg && (s1_op_reg == OP_LOAD), !done_reg, "load produced a result")
    `BIS_ASSERT_IMPL(a_inactive_zero, clk, rst_n, done_reg && ($past(nch_eff) < CHAN_CFG_W'(2)), val_reg[1] == '0, "inactive channel not zero")

endmodule
